@@ design/jet_pkg.sv @@
// ----------------------------------------------------------------------------
// jet_pkg
// Types, constants and control store for the julia escape-time engine.
// ----------------------------------------------------------------------------
package jet_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 10;
	localparam int WORD_W     = 32;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int SQ_W       = PROD_W - FRAC_BITS + 1;
	localparam int SUM_W      = ((SQ_W > WORD_W) ? SQ_W : WORD_W) + 2;
	localparam int MAG_W      = ((SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3);
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_W     = 4;

	localparam logic signed [WORD_W-1:0] CONST_RE_RST = -32'sd53687091;
	localparam logic signed [WORD_W-1:0] CONST_IM_RST = 32'sd72517838;
	localparam logic [COUNT_BITS-1:0]    LIMIT_RST    = COUNT_BITS'(64);

	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(WORD_MAX);
	localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(WORD_MIN);
	localparam logic [MAG_W-1:0]         MAG_THR  = MAG_W'(1) << (FRAC_BITS + 2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONST_RE = 2'd0,
		REG_CONST_IM = 2'd1,
		REG_LIMIT    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] start_re;
		logic signed [WORD_W-1:0] start_im;
	} pt_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] iterations;
		logic                  escaped;
	} res_t;

	typedef enum logic [1:0] {
		MUL_RR = 2'd0,
		MUL_II = 2'd1,
		MUL_RI = 2'd2
	} mul_op_t;

	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_SR    = 2'd1,
		WR_SI    = 2'd2,
		WR_CROSS = 2'd3
	} wr_dst_t;

	typedef enum logic [1:0] {
		CND_NONE     = 2'd0,
		CND_LIM_ZERO = 2'd1,
		CND_TEST     = 2'd2,
		CND_FINISH   = 2'd3
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic    mul_en;
		mul_op_t mul_op;
		wr_dst_t wr;
		logic    upd_z;
		cond_t   cond;
		step_t   target;
	} uc_word_t;

	localparam step_t ST_START = 4'd0;
	localparam step_t ST_LOOP  = 4'd3;
	localparam step_t ST_FIN   = 4'd10;

	function automatic uc_word_t uc_rom(input step_t step);
		uc_word_t w;
		w = '{mul_en: 1'b0, mul_op: MUL_RR, wr: WR_NONE, upd_z: 1'b0,
			cond: CND_NONE, target: ST_START};
		case (step)
			4'd0: begin
				w.mul_en = 1'b1; w.mul_op = MUL_RR;
				w.cond = CND_LIM_ZERO; w.target = ST_FIN;
			end
			4'd1: begin
				w.mul_en = 1'b1; w.mul_op = MUL_II; w.wr = WR_SR;
			end
			4'd2: begin
				w.wr = WR_SI;
			end
			4'd3: begin
				w.mul_en = 1'b1; w.mul_op = MUL_RI;
			end
			4'd4: begin
				w.wr = WR_CROSS;
			end
			4'd5: begin
				w.upd_z = 1'b1;
			end
			4'd6: begin
				w.mul_en = 1'b1; w.mul_op = MUL_RR;
			end
			4'd7: begin
				w.mul_en = 1'b1; w.mul_op = MUL_II; w.wr = WR_SR;
			end
			4'd8: begin
				w.wr = WR_SI;
			end
			4'd9: begin
				w.cond = CND_TEST; w.target = ST_LOOP;
			end
			4'd10: begin
				w.cond = CND_FINISH;
			end
			default: begin
				w.cond = CND_FINISH;
			end
		endcase
		return w;
	endfunction

endpackage

@@ design/julia_escape_time_top.sv @@
// ----------------------------------------------------------------------------
// julia_escape_time_top
// Fixed-point julia set escape-time engine run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// pt carries one starting point (start_re, start_im, signed Q4.28) and is
// taken when pt_valid is high and pt_stall is low. res carries iterations
// and escaped, delivered when res_valid is high and res_stall is low.
// cfg writes const_re (index 0), const_im (1) and iteration_limit (2) when
// cfg_valid and cfg_ready are high; cfg_ready is always high and writes to
// other indexes are dropped.
// One point is worked at a time. A single 32x32 multiplier with a registered
// product is stepped by an 11-word control store: three setup steps, then
// seven steps per iteration (cross product, z update, two squares, test).
// The result of a point is written in the final step, which the first step
// jumps to when the limit is zero; the next point can be taken in the same
// cycle as the result is shown. pt_stall is high from acceptance until the
// result enters the output register.
// The output register lets a new point be taken while a result waits; if
// res_stall holds a result, the next one waits in the final step.
// Reset sets the constants and limit to their defaults and empties the block.
// ----------------------------------------------------------------------------
module julia_escape_time_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pt_valid,
	output logic                              pt_stall,
	input  jet_pkg::pt_t                      pt,
	output logic                              res_valid,
	input  logic                              res_stall,
	output jet_pkg::res_t                     res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jet_pkg::WORD_W-1:0]        cfg_data
);

	logic signed [jet_pkg::WORD_W-1:0] const_re_q;
	logic signed [jet_pkg::WORD_W-1:0] const_im_q;
	logic [jet_pkg::COUNT_BITS-1:0]    limit_q;

	logic                              busy_q;
	jet_pkg::step_t                    step_q;
	logic                              res_valid_q;
	jet_pkg::res_t                     res_q;

	logic signed [jet_pkg::WORD_W-1:0] zr_q;
	logic signed [jet_pkg::WORD_W-1:0] zi_q;
	logic signed [jet_pkg::PROD_W-1:0] prod_q;
	logic signed [jet_pkg::SQ_W-1:0]   sr_q;
	logic signed [jet_pkg::SQ_W-1:0]   si_q;
	logic signed [jet_pkg::SQ_W-1:0]   cross_q;
	logic [jet_pkg::COUNT_BITS-1:0]    iter_q;
	logic                              esc_q;

	jet_pkg::uc_word_t                 uw;
	logic                              pt_beat;
	logic                              res_beat;
	logic signed [jet_pkg::WORD_W-1:0] mul_a;
	logic signed [jet_pkg::WORD_W-1:0] mul_b;
	logic signed [jet_pkg::PROD_W-1:0] mul_p;
	logic signed [jet_pkg::SUM_W-1:0]  re_sum;
	logic signed [jet_pkg::SUM_W-1:0]  im_sum;
	logic [jet_pkg::MAG_W-1:0]         mag;
	logic                              hit;
	logic [jet_pkg::COUNT_BITS-1:0]    iter_nx;
	logic                              last;
	logic                              fin_ok;

	function automatic logic signed [jet_pkg::WORD_W-1:0] sat_word(
		input logic signed [jet_pkg::SUM_W-1:0] v
	);
		logic signed [jet_pkg::WORD_W-1:0] r;
		if (v > jet_pkg::SUM_MAX) begin
			r = jet_pkg::WORD_MAX;
		end else if (v < jet_pkg::SUM_MIN) begin
			r = jet_pkg::WORD_MIN;
		end else begin
			r = v[jet_pkg::WORD_W-1:0];
		end
		return r;
	endfunction

	assign uw        = jet_pkg::uc_rom(step_q);
	assign pt_beat   = pt_valid && !busy_q;
	assign res_beat  = res_valid_q && !res_stall;
	assign pt_stall  = busy_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	assign mul_a  = (uw.mul_op == jet_pkg::MUL_II) ? zi_q : zr_q;
	assign mul_b  = (uw.mul_op == jet_pkg::MUL_RR) ? zr_q : zi_q;
	assign mul_p  = jet_pkg::PROD_W'(mul_a) * jet_pkg::PROD_W'(mul_b);
	assign re_sum = jet_pkg::SUM_W'(sr_q) - jet_pkg::SUM_W'(si_q)
		+ jet_pkg::SUM_W'(const_re_q);
	assign im_sum = jet_pkg::SUM_W'(cross_q) + jet_pkg::SUM_W'(const_im_q);
	assign mag    = jet_pkg::MAG_W'($unsigned(sr_q)) + jet_pkg::MAG_W'($unsigned(si_q));
	assign hit    = (mag >= jet_pkg::MAG_THR);
	assign iter_nx = iter_q + jet_pkg::COUNT_BITS'(1);
	assign last   = (iter_nx == limit_q);
	assign fin_ok = !res_valid_q || !res_stall;

	// config and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			const_re_q  <= jet_pkg::CONST_RE_RST;
			const_im_q  <= jet_pkg::CONST_IM_RST;
			limit_q     <= jet_pkg::LIMIT_RST;
			busy_q      <= 1'b0;
			step_q      <= jet_pkg::ST_START;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					jet_pkg::REG_CONST_RE: const_re_q <= cfg_data;
					jet_pkg::REG_CONST_IM: const_im_q <= cfg_data;
					jet_pkg::REG_LIMIT:    limit_q <= cfg_data[jet_pkg::COUNT_BITS-1:0];
					default: ;
				endcase
			end
			if (res_beat) begin
				res_valid_q <= 1'b0;
			end
			if (pt_beat) begin
				busy_q <= 1'b1;
				step_q <= jet_pkg::ST_START;
			end else if (busy_q) begin
				step_q <= step_q + jet_pkg::STEP_W'(1);
				case (uw.cond)
					jet_pkg::CND_LIM_ZERO: begin
						if (limit_q == '0) begin
							step_q <= uw.target;
						end
					end
					jet_pkg::CND_TEST: begin
						step_q <= (hit || last) ? jet_pkg::ST_FIN : uw.target;
					end
					jet_pkg::CND_FINISH: begin
						step_q <= step_q;
						if (fin_ok) begin
							res_valid_q <= 1'b1;
							busy_q      <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pt_beat) begin
			zr_q   <= pt.start_re;
			zi_q   <= pt.start_im;
			iter_q <= '0;
			esc_q  <= 1'b0;
		end else if (busy_q) begin
			if (uw.mul_en) begin
				prod_q <= mul_p;
			end
			case (uw.wr)
				jet_pkg::WR_SR:    sr_q <= jet_pkg::SQ_W'(prod_q >>> jet_pkg::FRAC_BITS);
				jet_pkg::WR_SI:    si_q <= jet_pkg::SQ_W'(prod_q >>> jet_pkg::FRAC_BITS);
				jet_pkg::WR_CROSS: cross_q <= jet_pkg::SQ_W'(prod_q >>> (jet_pkg::FRAC_BITS - 1));
				default: ;
			endcase
			if (uw.upd_z) begin
				zr_q <= sat_word(re_sum);
				zi_q <= sat_word(im_sum);
			end
			if (uw.cond == jet_pkg::CND_TEST) begin
				if (hit) begin
					esc_q <= 1'b1;
				end else begin
					iter_q <= iter_nx;
				end
			end
			if (uw.cond == jet_pkg::CND_FINISH && fin_ok) begin
				res_q.iterations <= iter_q;
				res_q.escaped    <= esc_q;
			end
		end
	end

endmodule

@@ design/jet_chk.sv @@
// ----------------------------------------------------------------------------
// jet_chk
// Port-level checks for the julia escape-time engine, bound to the top level.
// ----------------------------------------------------------------------------
module jet_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pt_valid,
	input logic                          pt_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input jet_pkg::res_t                 res
);

	// held result beat keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// one point in flight
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall |=> pt_stall)
		else $error("point taken while busy");

	// no result in the cycle after a point is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall |=> !$rose(res_valid))
		else $error("result too early");

	// new result frees the input side
	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !pt_stall)
		else $error("input still stalled after result");

endmodule

bind julia_escape_time_top jet_chk u_jet_chk (.*);
